// File: hw/rtl/psfp_pkg.sv
// Shared types and constants for the particulate sensor frame parser.
package psfp_pkg;

    localparam int NUM_FIELDS = 6;
    localparam int POS_W      = 5;
    localparam int SUM_W      = 13;
    localparam int WORD_W     = 16;

    localparam logic [POS_W-1:0] POS_START_A  = 5'd0;
    localparam logic [POS_W-1:0] POS_START_B  = 5'd1;
    localparam logic [POS_W-1:0] POS_LEN_HI   = 5'd2;
    localparam logic [POS_W-1:0] POS_LEN_LO   = 5'd3;
    localparam logic [POS_W-1:0] FIELD_FIRST  = 5'd4;
    localparam logic [POS_W-1:0] FIELD_LAST   = 5'd15;
    localparam logic [POS_W-1:0] SUM_BYTES    = 5'd30;
    localparam logic [POS_W-1:0] POS_CHECK_HI = 5'd30;
    localparam logic [POS_W-1:0] POS_LAST     = 5'd31;

    localparam logic [7:0] START_A   = 8'h42;
    localparam logic [7:0] START_B   = 8'h4D;
    localparam logic [7:0] LEN_HI    = 8'h00;
    localparam logic [7:0] LEN_LO    = 8'd28;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_LEN_ERR   = 2'd1,
        STATUS_DELIM_ERR = 2'd2,
        STATUS_SUM_ERR   = 2'd3
    } status_t;

    typedef logic [NUM_FIELDS-1:0][WORD_W-1:0] field_vec_t;

    typedef struct packed {
        status_t    status;
        field_vec_t conc;
    } result_t;

endpackage

// File: hw/rtl/particulate_sensor_frame_parser_core.sv
// Particulate sensor 32-byte frame parser: per-byte checks and result buffering.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-------------------------------------
//   in      | sink      | in_valid / in_stall | rx_byte, chunk_end
//   out     | source    | out_valid/out_stall | status, std_/atm_ pm1, pm2p5, pm10
//
// One byte is taken per cycle while in_stall is low; the parse state updates at the accepting edge.
// A beat with chunk_end set writes its result to the output register when it is empty or draining.
// A result that meets a stalled output register parks in a one-entry skid buffer;
// in_stall is high only while that skid entry is occupied.
// rst_n clears the parse state and the valid flags of both result buffers asynchronously.
module particulate_sensor_frame_parser_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        rx_byte,
    input  logic              chunk_end,
    output logic              out_valid,
    input  logic              out_stall,
    output psfp_pkg::status_t status,
    output logic [15:0]       std_pm1,
    output logic [15:0]       std_pm2p5,
    output logic [15:0]       std_pm10,
    output logic [15:0]       atm_pm1,
    output logic [15:0]       atm_pm2p5,
    output logic [15:0]       atm_pm10
);
    import psfp_pkg::*;

    // Chunk parse state.
    logic [POS_W-1:0] byte_position_reg,    byte_position_next;
    logic             first_frame_done_reg, first_frame_done_next;
    logic [SUM_W-1:0] running_sum_reg,      running_sum_next;
    logic             delimiter_ok_reg,     delimiter_ok_next;
    logic [7:0]       check_high_byte_reg,  check_high_byte_next;
    logic             checksum_ok_reg,      checksum_ok_next;
    field_vec_t       field_values_reg,     field_values_next;

    // Output register and skid entry.
    logic    out_valid_reg;
    result_t out_data_reg;
    logic    skid_valid_reg;
    result_t skid_data_reg;

    logic             in_accept;
    logic             out_fire;
    logic             new_valid;
    result_t          new_result;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] field_off;
    logic [2:0]       field_idx;

    assign in_stall  = skid_valid_reg;
    assign in_accept = in_valid && !in_stall;
    assign out_fire  = out_valid_reg && !out_stall;
    assign new_valid = in_accept && chunk_end;

    assign pos       = byte_position_reg;
    assign field_off = pos - FIELD_FIRST;
    assign field_idx = field_off[3:1];

    // Next parse state, folding in the current byte.
    always_comb
    begin
        byte_position_next    = pos + 5'd1;
        first_frame_done_next = first_frame_done_reg || (pos == POS_LAST);
        running_sum_next      = running_sum_reg;
        delimiter_ok_next     = delimiter_ok_reg;
        check_high_byte_next  = check_high_byte_reg;
        checksum_ok_next      = checksum_ok_reg;
        field_values_next     = field_values_reg;

        // Only the first frame of the chunk is examined.
        if (!first_frame_done_reg)
        begin
            if (pos < SUM_BYTES)
            begin
                running_sum_next = running_sum_reg + {{(SUM_W-8){1'b0}}, rx_byte};
            end

            case (pos)
                POS_START_A:
                begin
                    if (rx_byte != START_A) delimiter_ok_next = 1'b0;
                end
                POS_START_B:
                begin
                    if (rx_byte != START_B) delimiter_ok_next = 1'b0;
                end
                POS_LEN_HI:
                begin
                    if (rx_byte != LEN_HI) delimiter_ok_next = 1'b0;
                end
                POS_LEN_LO:
                begin
                    if (rx_byte != LEN_LO) delimiter_ok_next = 1'b0;
                end
                POS_CHECK_HI:
                begin
                    check_high_byte_next = rx_byte;
                end
                POS_LAST:
                begin
                    // Check word is big-endian; compare high and low bytes apart.
                    checksum_ok_next =
                        (check_high_byte_reg == {3'b000, running_sum_reg[SUM_W-1:8]}) &&
                        (rx_byte == running_sum_reg[7:0]);
                end
                default:
                begin
                end
            endcase

            // Even offset loads the high byte and clears the low; odd fills the low.
            if (pos inside {[FIELD_FIRST:FIELD_LAST]})
            begin
                for (int j = 0; j < NUM_FIELDS; j++)
                begin
                    if (field_idx == 3'(j))
                    begin
                        if (!pos[0])
                        begin
                            field_values_next[j] = {rx_byte, 8'h00};
                        end
                        else
                        begin
                            field_values_next[j][7:0] = rx_byte;
                        end
                    end
                end
            end
        end
    end

    // Result for a chunk that ends on this beat; length first, then delimiter, then sum.
    always_comb
    begin
        if (byte_position_next != '0)
        begin
            new_result.status = STATUS_LEN_ERR;
        end
        else if (!delimiter_ok_next)
        begin
            new_result.status = STATUS_DELIM_ERR;
        end
        else if (!checksum_ok_next)
        begin
            new_result.status = STATUS_SUM_ERR;
        end
        else
        begin
            new_result.status = STATUS_OK;
        end
        new_result.conc = (new_result.status == STATUS_OK) ? field_values_next : '0;
    end

    // Parse state: advance on every accepted beat, drop back to reset at chunk end.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_position_reg    <= '0;
            first_frame_done_reg <= 1'b0;
            running_sum_reg      <= '0;
            delimiter_ok_reg     <= 1'b1;
            check_high_byte_reg  <= '0;
            checksum_ok_reg      <= 1'b0;
            field_values_reg     <= '0;
        end
        else if (in_accept)
        begin
            if (chunk_end)
            begin
                byte_position_reg    <= '0;
                first_frame_done_reg <= 1'b0;
                running_sum_reg      <= '0;
                delimiter_ok_reg     <= 1'b1;
                check_high_byte_reg  <= '0;
                checksum_ok_reg      <= 1'b0;
                field_values_reg     <= '0;
            end
            else
            begin
                byte_position_reg    <= byte_position_next;
                first_frame_done_reg <= first_frame_done_next;
                running_sum_reg      <= running_sum_next;
                delimiter_ok_reg     <= delimiter_ok_next;
                check_high_byte_reg  <= check_high_byte_next;
                checksum_ok_reg      <= checksum_ok_next;
                field_values_reg     <= field_values_next;
            end
        end
    end

    // Output register with skid: refill when empty or draining, else park the new result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_fire)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= new_valid;
            end
        end
        else if (new_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_fire)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg <= skid_data_reg;
            end
            else if (new_valid)
            begin
                out_data_reg <= new_result;
            end
        end
        else if (new_valid)
        begin
            skid_data_reg <= new_result;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = out_data_reg.status;
    assign std_pm1   = out_data_reg.conc[0];
    assign std_pm2p5 = out_data_reg.conc[1];
    assign std_pm10  = out_data_reg.conc[2];
    assign atm_pm1   = out_data_reg.conc[3];
    assign atm_pm2p5 = out_data_reg.conc[4];
    assign atm_pm10  = out_data_reg.conc[5];

`ifndef NO_ASSERTIONS
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while output register empty");

    a_err_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status != STATUS_OK) |->
        (std_pm1 == 16'd0 && std_pm2p5 == 16'd0 && std_pm10 == 16'd0 &&
         atm_pm1 == 16'd0 && atm_pm2p5 == 16'd0 && atm_pm10 == 16'd0))
        else $error("concentrations nonzero on error status");

    a_chunk_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && chunk_end) |=>
        (byte_position_reg == '0 && !first_frame_done_reg && delimiter_ok_reg))
        else $error("parse state not cleared after chunk end");

    a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && chunk_end) |=> out_valid_reg)
        else $error("chunk end beat produced no result");
`endif

endmodule
